// ===== rtl/core/tsrr_pkg.sv =====
`default_nettype none

package tsrr_pkg;

    // Alphabet and symbol coding
    localparam int         ALPHA_SIZE   = 26;
    localparam int         SYM_W        = 5;
    localparam logic [4:0] LAST_LETTER  = 5'd25;
    localparam logic [4:0] SPACE_SYMBOL = 5'd26;

    typedef enum logic [1:0] {
        OP_DICT_LETTER = 2'd0,
        OP_DICT_END    = 2'd1,
        OP_TEXT_LETTER = 2'd2,
        OP_TEXT_SEP    = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_LOOK  = 2'd2
    } state_t;

    typedef enum logic [1:0] {
        MODE_WALK     = 2'd0,
        MODE_SUPPRESS = 2'd1,
        MODE_ECHO     = 2'd2
    } mode_t;

endpackage

`default_nettype wire

// ===== rtl/core/tsrr_ram.sv =====
`default_nettype none

module tsrr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/trie_shortest_root_replacer.sv =====
// Trie root replacer.
// Input channel (in_valid / in_stall) carries one beat per item: opcode and letter.
// Dictionary letters build word paths in a trie held in one child-table RAM
// (NODE_COUNT * 26 entries, each a child index plus a "child ends a root" mark);
// a dictionary word end marks the node reached. Sentence letters walk the trie
// and are echoed until the first root is met, then the rest of the word is
// dropped; a separator emits a space and restarts the walk.
// Output channel (out_valid / out_stall) carries zero or one beat per item:
// symbol (0..25 letter, 26 space) and the sticky overflow flag.
// Sequencing: dictionary letters and walking sentence letters pass through ST_IDLE
// and then ST_LOOK (registered RAM read, then update and write-back); word ends,
// separators, ignored letters and letters while echoing or suppressing finish in
// ST_IDLE. A result appears in the output register the cycle after its item finishes.
// Reset: the child table is swept to zero, one entry per cycle, over all
// NODE_COUNT * 26 entries (26624 at the default) with in_stall held high.
// A stalled output beat holds; the block takes no new item until the output
// register is free or being emptied in the same cycle.

`default_nettype none

module trie_shortest_root_replacer
    import tsrr_pkg::*;
#(
    parameter int NODE_COUNT = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  opcode,
    input  wire logic [4:0]  letter,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [SYM_W-1:0] symbol,
    output logic             overflow
);

    localparam int NODE_W      = $clog2(NODE_COUNT);
    localparam int CNT_W       = NODE_W + 1;
    localparam int TABLE_DEPTH = NODE_COUNT * ALPHA_SIZE;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int ENTRY_W     = NODE_W + 1;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [NODE_W-1:0]   ins_cur_reg, ins_cur_next;
    logic [ADDR_W-1:0]   ins_entry_reg, ins_entry_next;
    logic                ins_skip_reg, ins_skip_next;
    logic [CNT_W-1:0]    nodes_used_reg, nodes_used_next;
    logic [NODE_W-1:0]   qry_cur_reg, qry_cur_next;
    mode_t               mode_reg, mode_next;
    logic                ovf_reg, ovf_next;
    logic                pend_ins_reg, pend_ins_next;
    logic [SYM_W-1:0]    pend_letter_reg, pend_letter_next;
    logic [ADDR_W-1:0]   pend_addr_reg, pend_addr_next;
    logic                out_valid_reg, out_valid_next;
    logic [SYM_W-1:0]    symbol_reg, symbol_next;
    logic                out_ovf_reg, out_ovf_next;

    logic                accept;
    logic                letter_ok;
    logic [NODE_W-1:0]   rd_cursor;
    logic [ADDR_W-1:0]   rd_addr;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ENTRY_W-1:0]  ram_rdata;
    logic [NODE_W-1:0]   child;
    logic                child_mark;

    // Handshake
    assign in_stall  = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign symbol    = symbol_reg;
    assign overflow  = out_ovf_reg;

    // Child-table address of (cursor, letter)
    assign rd_cursor  = (opcode_t'(opcode) == OP_DICT_LETTER) ? ins_cur_reg : qry_cur_reg;
    assign rd_addr    = ADDR_W'(rd_cursor) * ADDR_W'(ALPHA_SIZE) + ADDR_W'(letter);
    assign child      = ram_rdata[NODE_W-1:0];
    assign child_mark = ram_rdata[NODE_W];

    tsrr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_child_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            ins_cur_reg    <= '0;
            ins_entry_reg  <= '0;
            ins_skip_reg   <= 1'b0;
            nodes_used_reg <= CNT_W'(1);
            qry_cur_reg    <= '0;
            mode_reg       <= MODE_WALK;
            ovf_reg        <= 1'b0;
            pend_ins_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            ins_cur_reg    <= ins_cur_next;
            ins_entry_reg  <= ins_entry_next;
            ins_skip_reg   <= ins_skip_next;
            nodes_used_reg <= nodes_used_next;
            qry_cur_reg    <= qry_cur_next;
            mode_reg       <= mode_next;
            ovf_reg        <= ovf_next;
            pend_ins_reg   <= pend_ins_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_letter_reg <= pend_letter_next;
        pend_addr_reg   <= pend_addr_next;
        symbol_reg      <= symbol_next;
        out_ovf_reg     <= out_ovf_next;
    end

    // Next state, memory write-back and output beat
    always_comb
    begin
        letter_ok        = letter inside {[5'd0:LAST_LETTER]};
        state_next       = state_reg;
        clr_addr_next    = clr_addr_reg;
        ins_cur_next     = ins_cur_reg;
        ins_entry_next   = ins_entry_reg;
        ins_skip_next    = ins_skip_reg;
        nodes_used_next  = nodes_used_reg;
        qry_cur_next     = qry_cur_reg;
        mode_next        = mode_reg;
        ovf_next         = ovf_reg;
        pend_ins_next    = pend_ins_reg;
        pend_letter_next = pend_letter_reg;
        pend_addr_next   = pend_addr_reg;
        out_valid_next   = out_valid_reg && out_stall;
        symbol_next      = symbol_reg;
        out_ovf_next     = out_ovf_reg;
        ram_we           = 1'b0;
        ram_waddr        = pend_addr_reg;
        ram_wdata        = '0;

        case (state_reg)
            // Sweep the child table to null after reset
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                if (clr_addr_reg == ADDR_W'(TABLE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + ADDR_W'(1);
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    case (opcode_t'(opcode))
                        OP_DICT_LETTER:
                        begin
                            if (letter_ok && !ins_skip_reg)
                            begin
                                pend_ins_next    = 1'b1;
                                pend_letter_next = letter;
                                pend_addr_next   = rd_addr;
                                state_next       = ST_LOOK;
                            end
                        end
                        OP_DICT_END:
                        begin
                            // mark lives in the parent's entry for this node
                            if (!ins_skip_reg && (ins_cur_reg != '0))
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = ins_entry_reg;
                                ram_wdata = {1'b1, ins_cur_reg};
                            end
                            ins_cur_next  = '0;
                            ins_skip_next = 1'b0;
                        end
                        OP_TEXT_LETTER:
                        begin
                            if (letter_ok)
                            begin
                                case (mode_reg)
                                    MODE_WALK:
                                    begin
                                        pend_ins_next    = 1'b0;
                                        pend_letter_next = letter;
                                        pend_addr_next   = rd_addr;
                                        state_next       = ST_LOOK;
                                    end
                                    MODE_SUPPRESS:
                                    begin
                                        // rest of word dropped
                                    end
                                    default:
                                    begin
                                        out_valid_next = 1'b1;
                                        symbol_next    = letter;
                                        out_ovf_next   = ovf_reg;
                                    end
                                endcase
                            end
                        end
                        default:
                        begin
                            qry_cur_next   = '0;
                            mode_next      = MODE_WALK;
                            out_valid_next = 1'b1;
                            symbol_next    = SPACE_SYMBOL;
                            out_ovf_next   = ovf_reg;
                        end
                    endcase
                end
            end

            // Child entry is on the read port now
            ST_LOOK:
            begin
                state_next = ST_IDLE;
                if (pend_ins_reg)
                begin
                    if (child == '0)
                    begin
                        if (nodes_used_reg < CNT_W'(NODE_COUNT))
                        begin
                            ram_we          = 1'b1;
                            ram_waddr       = pend_addr_reg;
                            ram_wdata       = {1'b0, nodes_used_reg[NODE_W-1:0]};
                            ins_cur_next    = nodes_used_reg[NODE_W-1:0];
                            ins_entry_next  = pend_addr_reg;
                            nodes_used_next = nodes_used_reg + CNT_W'(1);
                        end
                        else
                        begin
                            ovf_next      = 1'b1;
                            ins_skip_next = 1'b1;
                        end
                    end
                    else
                    begin
                        ins_cur_next   = child;
                        ins_entry_next = pend_addr_reg;
                    end
                end
                else
                begin
                    if (child == '0)
                    begin
                        mode_next = MODE_ECHO;
                    end
                    else
                    begin
                        qry_cur_next = child;
                        if (child_mark)
                        begin
                            mode_next = MODE_SUPPRESS;
                        end
                    end
                    out_valid_next = 1'b1;
                    symbol_next    = pend_letter_reg;
                    out_ovf_next   = ovf_reg;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Checks
    a_nodes_range: assert property (@(posedge clk) disable iff (!rst_n)
        (nodes_used_reg != '0) && (nodes_used_reg <= CNT_W'(NODE_COUNT)))
        else $error("node count out of range");

    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |=> ovf_reg)
        else $error("overflow flag cleared");

    a_skip_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        ins_skip_reg |-> ovf_reg)
        else $error("insert skip without overflow");

    a_look_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOK) |-> !out_valid_reg)
        else $error("output register busy during lookup");

endmodule

`default_nettype wire
